// File: src/line_rasterizer_all_octants_defines.svh
`ifndef LINE_RASTERIZER_ALL_OCTANTS_DEFINES_SVH
`define LINE_RASTERIZER_ALL_OCTANTS_DEFINES_SVH

// Assertion helpers. They expect clk and rst in scope.

// The consequent must hold in the same cycle as the antecedent.
`define LRAO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRAO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lrao_pkg.sv
`default_nettype none

package lrao_pkg;

  localparam int COORD_BITS = 6;
  // Deltas between two coordinates need one more bit than a coordinate.
  localparam int DELTA_BITS = COORD_BITS + 1;
  // Decision value: twice a delta plus a sign bit.
  localparam int ERR_BITS = DELTA_BITS + 2;

  localparam int IN_BITS = 4 * COORD_BITS;
  localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * COORD_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETUP,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;   // capture the endpoints
    logic prep;   // form the deltas and choose the major axis
    logic setup;  // orient the run and seed the decision value
    logic step;   // emit one pixel and advance
  } cmd_t;

  typedef struct packed {
    logic major_zero;
    logic last_step;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: src/line_rasterizer_all_octants.sv
// Channel  Dir  tdata fields (low bit up)            tlast       tuser
// s        in   start_x, start_y, end_x, end_y        -           -
// m        out  pixel_x, pixel_y                      last_pixel  decision_positive
//
// A segment is loaded (ST_IDLE, ST_LOAD) and set up (ST_SETUP), then ST_RUN emits
// N pixels (N = larger of |dx| and |dy|, 0 to 63), one per cycle while the output
// is free, a rate set by the per-pixel loop in the datapath (decision update and
// coordinate step). A new segment is taken once the last pixel word has entered
// the output register. A stalled output holds the run in place. Reset is
// synchronous and clears the controller and the output valid.
`default_nettype none

module line_rasterizer_all_octants (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // start_x [5:0], start_y [11:6], end_x [17:12], end_y [23:18]
  input  wire logic [lrao_pkg::IN_TDATA_BITS-1:0] s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // pixel_x [5:0], pixel_y [11:6], zero above
  output logic [lrao_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
  output logic                                   m_tlast,
  // decision_positive [0]
  output logic                                   m_tuser
);
  import lrao_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lrao_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrao_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// File: src/lrao_ctrl.sv
`default_nettype none

module lrao_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire lrao_pkg::stat_t stat,
  output lrao_pkg::cmd_t      cmd
);
  import lrao_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        // A zero-length segment has no pixels at all.
        if (stat.major_zero) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.out_free && stat.last_step) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.prep  = 1'b0;
    cmd.setup = 1'b0;
    cmd.step  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_LOAD: begin
        cmd.prep = 1'b1;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_RUN: begin
        cmd.step = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/lrao_datapath.sv
`default_nettype none
`include "line_rasterizer_all_octants_defines.svh"

module lrao_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [lrao_pkg::IN_TDATA_BITS-1:0] s_tdata,
  input  wire lrao_pkg::cmd_t                   cmd,
  output lrao_pkg::stat_t                       stat,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [lrao_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  output logic                                  m_tlast,
  output logic                                  m_tuser
);
  import lrao_pkg::*;

  localparam int CM = COORD_BITS - 1;
  localparam int DM = DELTA_BITS - 1;
  localparam int EM = ERR_BITS - 1;

  // Captured endpoints.
  logic [CM:0] ax, ay, bx, by;

  // Deltas and axis choice.
  logic [DM:0] dx, dy, adx, ady;
  logic [DM:0] dx_r, dy_r, adx_r, ady_r;
  logic        steep_case;

  // Run state.
  logic [CM:0] cur_major, cur_minor;
  logic [EM:0] error_term;
  logic [CM:0] steps_left;
  logic        minor_step_negative;
  logic [DM:0] major_delta, minor_delta;

  // Setup terms.
  logic [DM:0] dmaj, dmin, major_d_c, minor_d_c;
  logic        swap, dmin_pos, minor_neg_c;
  logic [EM:0] err_init;

  // Step terms.
  logic        pos;
  logic [EM:0] err_inc_pos, err_inc_neg;

  // Output register.
  logic        out_valid;
  logic [CM:0] out_x, out_y;
  logic        out_pos, out_last;
  logic [OUT_BITS-1:0] out_word;

  always_comb begin
    dx  = {bx[CM], bx} - {ax[CM], ax};
    dy  = {by[CM], by} - {ay[CM], ay};
    adx = dx[DM] ? (~dx + DELTA_BITS'(1)) : dx;
    ady = dy[DM] ? (~dy + DELTA_BITS'(1)) : dy;
  end

  always_comb begin
    dmaj      = steep_case ? dy_r : dx_r;
    dmin      = steep_case ? dx_r : dy_r;
    major_d_c = steep_case ? ady_r : adx_r;
    minor_d_c = steep_case ? adx_r : ady_r;
    // Walking from the far end reverses the sign of the minor step.
    swap        = dmaj[DM];
    dmin_pos    = !dmin[DM] && (dmin != '0);
    minor_neg_c = swap ? dmin_pos : dmin[DM];
    err_init    = {1'b0, minor_d_c, 1'b0} - {2'b00, major_d_c};
  end

  always_comb begin
    pos         = !error_term[EM] && (error_term != '0);
    err_inc_pos = {1'b0, minor_delta, 1'b0} - {1'b0, major_delta, 1'b0};
    err_inc_neg = {1'b0, minor_delta, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax <= s_tdata[CM:0];
      ay <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      bx <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
      by <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    end
    if (cmd.prep) begin
      dx_r  <= dx;
      dy_r  <= dy;
      adx_r <= adx;
      ady_r <= ady;
      // Equal magnitudes count as steep.
      steep_case <= !(ady < adx);
    end
    if (cmd.setup) begin
      major_delta         <= major_d_c;
      minor_delta         <= minor_d_c;
      minor_step_negative <= minor_neg_c;
      error_term          <= err_init;
      steps_left          <= major_d_c[CM:0];
      if (steep_case) begin
        cur_major <= swap ? by : ay;
        cur_minor <= swap ? bx : ax;
      end else begin
        cur_major <= swap ? bx : ax;
        cur_minor <= swap ? by : ay;
      end
    end
    if (cmd.step) begin
      out_x    <= steep_case ? cur_minor : cur_major;
      out_y    <= steep_case ? cur_major : cur_minor;
      out_pos  <= pos;
      out_last <= (steps_left == COORD_BITS'(1));
      if (pos) begin
        cur_minor  <= minor_step_negative ? (cur_minor - COORD_BITS'(1))
                                          : (cur_minor + COORD_BITS'(1));
        error_term <= error_term + err_inc_pos;
      end else begin
        error_term <= error_term + err_inc_neg;
      end
      cur_major  <= cur_major + COORD_BITS'(1);
      steps_left <= steps_left - COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.out_free   = !out_valid || m_tready;
    stat.major_zero = ((steep_case ? ady_r : adx_r) == '0);
    stat.last_step  = (steps_left == COORD_BITS'(1));
  end

  assign out_word = {out_y, out_x};
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_BITS'(out_word);
  assign m_tlast  = out_last;
  assign m_tuser  = out_pos;

  `LRAO_ASSERT_SAME(a_no_overwrite, out_valid && !m_tready, !cmd.step, "pixel overwritten")
  `LRAO_ASSERT_SAME(a_step_has_work, cmd.step, steps_left != '0, "step with no pixels left")
  `LRAO_ASSERT_NEXT(a_last_empties, cmd.step && stat.last_step, steps_left == '0, "run overran")

endmodule

`default_nettype wire

// File: tb/sv/line_rasterizer_all_octants_test.sv
`timescale 1ns / 1ps

module line_rasterizer_all_octants_test;
  import lrao_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 70;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   positive;
    logic   last;
  } pixel_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tlast;
  logic                      m_tuser;

  line_rasterizer_all_octants u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Pixels still owed by the block, oldest first.
  pixel_t pending_pixels[$];
  int     error_count = 0;
  int     idle_cycles = 0;
  int     tx_gap_pct = 30;
  int     rx_stall_pct = 30;
  int     rx_stall_left = 0;

  // Rasteriser state as the block keeps it between segments.
  bit steep_run;
  bit minor_down;
  int run_major;
  int run_minor;
  int decision;
  int pixels_left;
  int major_span;
  int minor_span;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Works out the pixel words for one segment and queues them.
  function automatic void trace_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int     dx;
    int     dy;
    int     a_maj;
    int     a_min;
    int     b_maj;
    int     b_min;
    int     swap;
    int     dmin;
    pixel_t px;
    dx = int'(ex) - int'(sx);
    dy = int'(ey) - int'(sy);
    steep_run = !((dy < 0 ? -dy : dy) < (dx < 0 ? -dx : dx));
    if (steep_run) begin
      a_maj = sy; a_min = sx; b_maj = ey; b_min = ex;
    end else begin
      a_maj = sx; a_min = sy; b_maj = ex; b_min = ey;
    end
    if (a_maj > b_maj) begin
      swap = a_maj; a_maj = b_maj; b_maj = swap;
      swap = a_min; a_min = b_min; b_min = swap;
    end
    major_span = b_maj - a_maj;
    dmin = b_min - a_min;
    minor_down = dmin < 0;
    minor_span = dmin < 0 ? -dmin : dmin;
    run_major = a_maj;
    run_minor = a_min;
    decision = 2 * minor_span - major_span;
    pixels_left = major_span;
    while (pixels_left > 0) begin
      px.positive = decision > 0;
      px.x = steep_run ? coord_t'(run_minor) : coord_t'(run_major);
      px.y = steep_run ? coord_t'(run_major) : coord_t'(run_minor);
      px.last = pixels_left == 1;
      pending_pixels.push_back(px);
      if (px.positive) begin
        run_minor += minor_down ? -1 : 1;
        decision += 2 * (minor_span - major_span);
      end else begin
        decision += 2 * minor_span;
      end
      run_major++;
      pixels_left--;
    end
  endfunction

  // Sink side: random stalls, mostly short with the odd long one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall_left <= 0;
    end else if (rx_stall_left > 0) begin
      m_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      rx_stall_left <= pick_gap(rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel word x=%0d y=%0d", $time,
                 $signed(m_tdata[COORD_BITS-1:0]),
                 $signed(m_tdata[2*COORD_BITS-1:COORD_BITS]));
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (coord_t'(m_tdata[COORD_BITS-1:0]) !== want.x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, want.x,
                   $signed(m_tdata[COORD_BITS-1:0]));
          error_count++;
        end
        if (coord_t'(m_tdata[2*COORD_BITS-1:COORD_BITS]) !== want.y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, want.y,
                   $signed(m_tdata[2*COORD_BITS-1:COORD_BITS]));
          error_count++;
        end
        if (m_tuser !== want.positive) begin
          $display("%0t: decision_positive expected %0b actual %0b", $time,
                   want.positive, m_tuser);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last_pixel expected %0b actual %0b", $time, want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Holds s_tvalid high across back-to-back words so that it is never
  // lowered and raised in the same step.
  task automatic send_segment(input coord_t sx, input coord_t sy, input coord_t ex,
                              input coord_t ey);
    int gap;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ey, ex, sy, sx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    trace_segment(sx, sy, ex, ey);
  endtask

  // Mostly short segments near a random start, the rest spanning the grid.
  task automatic send_random_segment();
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    sx = coord_t'($urandom_range(0, 63));
    sy = coord_t'($urandom_range(0, 63));
    if ($urandom_range(0, 2) == 0) begin
      ex = coord_t'($urandom_range(0, 63));
      ey = coord_t'($urandom_range(0, 63));
    end else begin
      ex = coord_t'(int'(sx) + int'($urandom_range(0, 16)) - 8);
      ey = coord_t'(int'(sy) + int'($urandom_range(0, 16)) - 8);
    end
    send_segment(sx, sy, ex, ey);
  endtask

  // Lowers s_tvalid and waits on the clock before polling the queue, so that the next
  // word is never raised in the step that lowered s_tvalid.
  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_segments();
    tx_gap_pct = 30;
    rx_stall_pct = 30;
    send_segment(0, 0, 0, 0);
    send_segment(7, -3, 7, -3);
    send_segment(-32, -32, 31, 31);
    send_segment(31, -32, -32, 31);
    send_segment(-32, 0, 31, 0);
    send_segment(31, 5, -32, 5);
    send_segment(-4, -32, -4, 31);
    send_segment(10, 31, 10, -32);
    send_segment(0, 0, 1, 0);
    send_segment(0, 0, 0, -1);
    send_segment(0, 0, 9, 4);
    send_segment(0, 0, 9, -4);
    send_segment(0, 0, -9, 4);
    send_segment(0, 0, -9, -4);
    send_segment(0, 0, 4, 9);
    send_segment(0, 0, -4, 9);
    send_segment(0, 0, 4, -9);
    send_segment(0, 0, -4, -9);
    send_segment(3, 3, -3, -3);
    send_segment(-32, 31, 31, 30);
    send_segment(31, -31, -32, 30);
    send_segment(-1, -1, -1, -1);
  endtask

  task automatic test_random_segments();
    tx_gap_pct = 30;
    rx_stall_pct = 25;
    repeat (100) send_random_segment();
  endtask

  task automatic test_back_to_back();
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    repeat (40) send_random_segment();
  endtask

  task automatic test_output_backpressure();
    tx_gap_pct = 10;
    rx_stall_pct = 60;
    repeat (40) send_random_segment();
  endtask

  task automatic test_drain_between_bursts();
    tx_gap_pct = 20;
    rx_stall_pct = 30;
    repeat (3) begin
      repeat (10) send_random_segment();
      drain_pixels();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_segments();
    test_random_segments();
    test_back_to_back();
    test_output_backpressure();
    test_drain_between_bursts();
    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d pixel words never arrived", $time, pending_pixels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
